// ===== hw/rtl/wpm_pkg.sv =====
// Shared types, constants and helpers of the waveform pulse measurement block.
// No dependencies; every other file imports this package.
package wpm_pkg;

    localparam int SMP_W        = 16;
    localparam int RECORD_DEPTH = 4096;
    localparam int IDX_W        = $clog2(RECORD_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int BIN_SHIFT    = 3;
    localparam int BIN_W        = SMP_W - BIN_SHIFT;
    localparam int NBINS        = 2 ** BIN_W;
    localparam int FRAC_W       = 8;
    localparam int PER_W        = IDX_W + FRAC_W;
    localparam int DIV_CNT_W    = $clog2(PER_W);
    localparam int DEB_W        = 12;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = Q_PTR_W + 1;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [SMP_W-1:0] CODE_MIN = 16'sh8000;
    localparam logic signed [SMP_W-1:0] CODE_MAX = 16'sh7fff;

    // register index of the APB map
    localparam logic REG_DEBOUNCE = 1'b0;

    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        addr;
        logic signed [SMP_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] min;
        logic signed [SMP_W-1:0] max;
        logic [CNT_W-1:0]        n;
    } rec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] min_code;
        logic signed [SMP_W-1:0] max_code;
        logic signed [SMP_W-1:0] base_code;
        logic signed [SMP_W-1:0] top_code;
        logic signed [SMP_W-1:0] mid_code;
        logic [CNT_W-1:0]        rising_count;
        logic [CNT_W-1:0]        falling_count;
        logic [PER_W-1:0]        rise_spacing;
        logic [PER_W-1:0]        fall_spacing;
        logic [IDX_W-1:0]        first_rising;
        logic [IDX_W-1:0]        first_falling;
    } res_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_H_RD,
        BK_H_BIN,
        BK_H_UPD,
        BK_Z_RD,
        BK_Z_WR,
        BK_MID,
        BK_MID2,
        BK_E_RD,
        BK_E_CHK,
        BK_DS_R,
        BK_DIV_R,
        BK_DS_F,
        BK_DIV_F,
        BK_FIN
    } back_state_t;

    // histogram bin of a sample: offset binary, shifted down
    function automatic logic [BIN_W-1:0] bin_of(input logic signed [SMP_W-1:0] s);
        logic [SMP_W-1:0] b;
        b = {~s[SMP_W-1], s[SMP_W-2:0]};
        return b[SMP_W-1:BIN_SHIFT];
    endfunction

    // lowest code of a bin
    function automatic logic signed [SMP_W-1:0] code_of(input logic [BIN_W-1:0] bin);
        logic [SMP_W-1:0] c;
        c = {bin, {BIN_SHIFT{1'b0}}};
        return signed'({~c[SMP_W-1], c[SMP_W-2:0]});
    endfunction

endpackage

// ===== hw/rtl/wpm_smp_if.sv =====
// Sample channel: valid/ready handshake with one sample and its last mark.
// Depends on wpm_pkg.
interface wpm_smp_if;
    import wpm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== hw/rtl/wpm_res_if.sv =====
// Result channel: valid/ready handshake with the per-record summary fields.
// Depends on wpm_pkg.
interface wpm_res_if;
    import wpm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] min_code;
    logic signed [SMP_W-1:0] max_code;
    logic signed [SMP_W-1:0] base_code;
    logic signed [SMP_W-1:0] top_code;
    logic signed [SMP_W-1:0] mid_code;
    logic [CNT_W-1:0]        rising_count;
    logic [CNT_W-1:0]        falling_count;
    logic [PER_W-1:0]        rise_spacing;
    logic [PER_W-1:0]        fall_spacing;
    logic [IDX_W-1:0]        first_rising;
    logic [IDX_W-1:0]        first_falling;

    modport source (output valid, output min_code, output max_code, output base_code,
                    output top_code, output mid_code, output rising_count,
                    output falling_count, output rise_spacing, output fall_spacing,
                    output first_rising, output first_falling, input ready);
    modport sink   (input valid, input min_code, input max_code, input base_code,
                    input top_code, input mid_code, input rising_count,
                    input falling_count, input rise_spacing, input fall_spacing,
                    input first_rising, input first_falling, output ready);
endinterface

// ===== hw/rtl/wpm_front.sv =====
// Front end: accepts samples, writes the sample store, tracks min/max and count,
// and hands a record descriptor to the queue on last. Depends on wpm_pkg, wpm_smp_if.
module wpm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    wpm_smp_if.sink              smp,
    input  wpm_pkg::back_stat_t  bstat,
    input  wpm_pkg::q_stat_t     qstat,
    output wpm_pkg::store_wr_t   st_wr,
    output logic                 push,
    output wpm_pkg::rec_t        rec
);
    import wpm_pkg::*;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SMP_W-1:0] min_reg, min_next;
    logic signed [SMP_W-1:0] max_reg, max_next;
    logic                    acc;
    logic                    keep;
    logic signed [SMP_W-1:0] min_upd, max_upd;
    logic [CNT_W-1:0]        cnt_upd;

    // the store belongs to the back end while a record is pending
    assign smp.ready = !bstat.busy && qstat.empty;
    assign acc       = smp.valid && smp.ready;
    assign keep      = (cnt_reg < CNT_W'(RECORD_DEPTH));

    // running values including the current request
    always_comb
    begin
        min_upd = min_reg;
        max_upd = max_reg;
        cnt_upd = cnt_reg;
        if (keep)
        begin
            cnt_upd = cnt_reg + 1'b1;
            if (smp.sample < min_reg)
                min_upd = smp.sample;
            if (smp.sample > max_reg)
                max_upd = smp.sample;
        end
    end

    always_comb
    begin
        st_wr.en   = acc && keep;
        st_wr.addr = cnt_reg[IDX_W-1:0];
        st_wr.data = smp.sample;
        push       = acc && smp.last;
        rec.min    = min_upd;
        rec.max    = max_upd;
        rec.n      = cnt_upd;
    end

    // record accumulators, restarted after each closing sample
    always_comb
    begin
        cnt_next = cnt_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (acc)
        begin
            if (smp.last)
            begin
                cnt_next = '0;
                min_next = CODE_MAX;
                max_next = CODE_MIN;
            end
            else
            begin
                cnt_next = cnt_upd;
                min_next = min_upd;
                max_next = max_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            min_reg <= CODE_MAX;
            max_reg <= CODE_MIN;
        end
        else
        begin
            cnt_reg <= cnt_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

// ===== hw/rtl/wpm_queue.sv =====
// Short descriptor queue between front and back end.
// Depends on wpm_pkg.
module wpm_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wpm_pkg::rec_t     din,
    input  logic              pop,
    output wpm_pkg::rec_t     dout,
    output wpm_pkg::q_stat_t  qstat
);
    import wpm_pkg::*;

    rec_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign dout        = mem_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== hw/rtl/wpm_back.sv =====
// Back end: sample store, the two histograms, mode search, crossing pass,
// period divider and result register. Depends on wpm_pkg, wpm_res_if.
module wpm_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wpm_pkg::store_wr_t      st_wr,
    input  wpm_pkg::q_stat_t        qstat,
    input  wpm_pkg::rec_t           rec,
    output logic                    pop,
    input  logic [wpm_pkg::DEB_W-1:0] debounce,
    output wpm_pkg::back_stat_t     bstat,
    wpm_res_if.source               res
);
    import wpm_pkg::*;

    // memories
    logic signed [SMP_W-1:0] store_mem [RECORD_DEPTH];
    logic [CNT_W-1:0]        lo_mem [NBINS];
    logic [CNT_W-1:0]        hi_mem [NBINS];
    logic signed [SMP_W-1:0] st_rd_reg;
    logic [CNT_W-1:0]        lo_rd_reg, hi_rd_reg;

    back_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        t_reg, t_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic signed [SMP_W-1:0] min_reg, min_next;
    logic signed [SMP_W-1:0] max_reg, max_next;
    logic signed [SMP_W-1:0] pmid_reg, pmid_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic                    low_reg, low_next;
    logic [CNT_W-1:0]        lo_best_reg, lo_best_next;
    logic [BIN_W-1:0]        lo_bin_reg, lo_bin_next;
    logic [CNT_W-1:0]        hi_best_reg, hi_best_next;
    logic [BIN_W-1:0]        hi_bin_reg, hi_bin_next;
    logic signed [SMP_W-1:0] base_reg, base_next;
    logic signed [SMP_W-1:0] top_reg, top_next;
    logic signed [SMP_W-1:0] mid_reg, mid_next;
    logic signed [SMP_W-1:0] prev_reg, prev_next;
    logic [DEB_W-1:0]        skip_reg, skip_next;
    logic [CNT_W-1:0]        rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]        fcnt_reg, fcnt_next;
    logic [IDX_W-1:0]        rfirst_reg, rfirst_next;
    logic [IDX_W-1:0]        rlast_reg, rlast_next;
    logic [IDX_W-1:0]        ffirst_reg, ffirst_next;
    logic [IDX_W-1:0]        flast_reg, flast_next;
    logic [PER_W-1:0]        rper_reg, rper_next;
    logic [PER_W-1:0]        fper_reg, fper_next;
    logic [PER_W-1:0]        dnum_reg, dnum_next;
    logic [IDX_W-1:0]        drem_reg, drem_next;
    logic [IDX_W-1:0]        dden_reg, dden_next;
    logic [DIV_CNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [BIN_W-1:0]        clr_reg, clr_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;

    // memory control
    logic [BIN_W-1:0]        h_raddr, h_waddr;
    logic [CNT_W-1:0]        h_wdata;
    logic                    lo_we, hi_we;

    // datapath helpers
    logic signed [SMP_W:0]   pdiff;
    logic signed [SMP_W:0]   mdiff, mhalf, msum;
    logic [CNT_W-1:0]        hcnt;
    logic                    is_rise, is_fall;
    logic [IDX_W:0]          rem_sh;
    logic                    ge;
    logic [IDX_W-1:0]        rem_new;
    logic [PER_W-1:0]        num_new;
    logic                    t_end;

    assign bstat.busy = (state_reg != BK_IDLE);

    // result channel
    assign res.valid          = res_valid_reg;
    assign res.min_code       = res_reg.min_code;
    assign res.max_code       = res_reg.max_code;
    assign res.base_code      = res_reg.base_code;
    assign res.top_code       = res_reg.top_code;
    assign res.mid_code       = res_reg.mid_code;
    assign res.rising_count   = res_reg.rising_count;
    assign res.falling_count  = res_reg.falling_count;
    assign res.rise_spacing   = res_reg.rise_spacing;
    assign res.fall_spacing   = res_reg.fall_spacing;
    assign res.first_rising   = res_reg.first_rising;
    assign res.first_falling  = res_reg.first_falling;

    // sample store: written by the front end, read at the pass index
    always_ff @(posedge clk)
    begin
        if (st_wr.en)
            store_mem[st_wr.addr] <= st_wr.data;
        st_rd_reg <= store_mem[t_reg[IDX_W-1:0]];
    end

    // histograms
    always_ff @(posedge clk)
    begin
        if (lo_we)
            lo_mem[h_waddr] <= h_wdata;
        lo_rd_reg <= lo_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hi_we)
            hi_mem[h_waddr] <= h_wdata;
        hi_rd_reg <= hi_mem[h_raddr];
    end

    // arithmetic shared by the states
    always_comb
    begin
        pdiff   = {max_reg[SMP_W-1], max_reg} - {min_reg[SMP_W-1], min_reg};
        mdiff   = {top_reg[SMP_W-1], top_reg} - {base_reg[SMP_W-1], base_reg};
        mhalf   = (mdiff + {{SMP_W{1'b0}}, mdiff[SMP_W]}) >>> 1;
        msum    = {base_reg[SMP_W-1], base_reg} + mhalf;
        hcnt    = (low_reg ? lo_rd_reg : hi_rd_reg) + 1'b1;
        is_rise = (st_rd_reg >= mid_reg) && (prev_reg < mid_reg);
        is_fall = (st_rd_reg <= mid_reg) && (prev_reg > mid_reg);
        rem_sh  = {drem_reg, dnum_reg[PER_W-1]};
        ge      = (rem_sh >= {1'b0, dden_reg});
        rem_new = ge ? IDX_W'(rem_sh - {1'b0, dden_reg}) : rem_sh[IDX_W-1:0];
        num_new = {dnum_reg[PER_W-2:0], ge};
        t_end   = ((t_reg + 1'b1) == n_reg);
    end

    // sequencer: next state, memory control and register updates
    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        pmid_next      = pmid_reg;
        bin_next       = bin_reg;
        low_next       = low_reg;
        lo_best_next   = lo_best_reg;
        lo_bin_next    = lo_bin_reg;
        hi_best_next   = hi_best_reg;
        hi_bin_next    = hi_bin_reg;
        base_next      = base_reg;
        top_next       = top_reg;
        mid_next       = mid_reg;
        prev_next      = prev_reg;
        skip_next      = skip_reg;
        rcnt_next      = rcnt_reg;
        fcnt_next      = fcnt_reg;
        rfirst_next    = rfirst_reg;
        rlast_next     = rlast_reg;
        ffirst_next    = ffirst_reg;
        flast_next     = flast_reg;
        rper_next      = rper_reg;
        fper_next      = fper_reg;
        dnum_next      = dnum_reg;
        drem_next      = drem_reg;
        dden_next      = dden_reg;
        dcnt_next      = dcnt_reg;
        clr_next       = clr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        h_raddr        = bin_of(st_rd_reg);
        h_waddr        = bin_reg;
        h_wdata        = hcnt;
        lo_we          = 1'b0;
        hi_we          = 1'b0;

        if (res.valid && res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            // sweep both histograms to zero after reset
            BK_CLEAR:
            begin
                h_waddr  = clr_reg;
                h_wdata  = '0;
                lo_we    = 1'b1;
                hi_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BIN_W'(NBINS - 1))
                    state_next = BK_IDLE;
            end

            // take the next record descriptor
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop          = 1'b1;
                    n_next       = rec.n;
                    min_next     = rec.min;
                    max_next     = rec.max;
                    t_next       = '0;
                    lo_best_next = '0;
                    lo_bin_next  = '0;
                    hi_best_next = '0;
                    hi_bin_next  = '0;
                    state_next   = BK_H_RD;
                end
            end

            // histogram pass: store read, bin read, increment
            BK_H_RD:
            begin
                pmid_next  = SMP_W'(min_reg + pdiff[SMP_W:1]);
                state_next = BK_H_BIN;
            end

            BK_H_BIN:
            begin
                bin_next   = bin_of(st_rd_reg);
                low_next   = (st_rd_reg < pmid_reg);
                state_next = BK_H_UPD;
            end

            BK_H_UPD:
            begin
                lo_we = low_reg;
                hi_we = !low_reg;
                // running mode, lowest bin on a tie
                if (low_reg)
                begin
                    if ((hcnt > lo_best_reg) ||
                        ((hcnt == lo_best_reg) && (bin_reg < lo_bin_reg)))
                    begin
                        lo_best_next = hcnt;
                        lo_bin_next  = bin_reg;
                    end
                end
                else
                begin
                    if ((hcnt > hi_best_reg) ||
                        ((hcnt == hi_best_reg) && (bin_reg < hi_bin_reg)))
                    begin
                        hi_best_next = hcnt;
                        hi_bin_next  = bin_reg;
                    end
                end
                if (t_end)
                begin
                    t_next     = '0;
                    state_next = BK_Z_RD;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = BK_H_RD;
                end
            end

            // zero the bins this record touched
            BK_Z_RD:
            begin
                state_next = BK_Z_WR;
            end

            BK_Z_WR:
            begin
                h_waddr = bin_of(st_rd_reg);
                h_wdata = '0;
                lo_we   = 1'b1;
                hi_we   = 1'b1;
                if (t_end)
                begin
                    t_next     = '0;
                    state_next = BK_MID;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = BK_Z_RD;
                end
            end

            // base and top with empty-histogram defaults, then midpoint
            BK_MID:
            begin
                base_next  = (lo_best_reg == '0) ? CODE_MIN : code_of(lo_bin_reg);
                top_next   = (hi_best_reg == '0) ? CODE_MAX : code_of(hi_bin_reg);
                state_next = BK_MID2;
            end

            BK_MID2:
            begin
                mid_next   = msum[SMP_W-1:0];
                rcnt_next  = '0;
                fcnt_next  = '0;
                rfirst_next = '0;
                rlast_next = '0;
                ffirst_next = '0;
                flast_next = '0;
                skip_next  = '0;
                state_next = BK_E_RD;
            end

            // crossing pass: a read state, then a check state for each sample
            BK_E_RD:
            begin
                state_next = BK_E_CHK;
            end

            BK_E_CHK:
            begin
                prev_next = st_rd_reg;
                if (t_reg != '0)
                begin
                    if (skip_reg != '0)
                        skip_next = skip_reg - 1'b1;
                    else if (is_rise)
                    begin
                        if (rcnt_reg == '0)
                            rfirst_next = t_reg[IDX_W-1:0];
                        rlast_next = t_reg[IDX_W-1:0];
                        rcnt_next  = rcnt_reg + 1'b1;
                        skip_next  = debounce;
                    end
                    else if (is_fall)
                    begin
                        if (fcnt_reg == '0)
                            ffirst_next = t_reg[IDX_W-1:0];
                        flast_next = t_reg[IDX_W-1:0];
                        fcnt_next  = fcnt_reg + 1'b1;
                        skip_next  = debounce;
                    end
                end
                if (t_end)
                    state_next = BK_DS_R;
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = BK_E_RD;
                end
            end

            // period = (last - first) * 256 / (count - 1), one bit a cycle
            BK_DS_R:
            begin
                if (rcnt_reg < CNT_W'(2))
                begin
                    rper_next  = '0;
                    state_next = BK_DS_F;
                end
                else
                begin
                    dnum_next  = {rlast_reg - rfirst_reg, {FRAC_W{1'b0}}};
                    dden_next  = rcnt_reg[IDX_W-1:0] - 1'b1;
                    drem_next  = '0;
                    dcnt_next  = '0;
                    state_next = BK_DIV_R;
                end
            end

            BK_DIV_R:
            begin
                dnum_next = num_new;
                drem_next = rem_new;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(PER_W - 1))
                begin
                    rper_next  = num_new;
                    state_next = BK_DS_F;
                end
            end

            BK_DS_F:
            begin
                if (fcnt_reg < CNT_W'(2))
                begin
                    fper_next  = '0;
                    state_next = BK_FIN;
                end
                else
                begin
                    dnum_next  = {flast_reg - ffirst_reg, {FRAC_W{1'b0}}};
                    dden_next  = fcnt_reg[IDX_W-1:0] - 1'b1;
                    drem_next  = '0;
                    dcnt_next  = '0;
                    state_next = BK_DIV_F;
                end
            end

            BK_DIV_F:
            begin
                dnum_next = num_new;
                drem_next = rem_new;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(PER_W - 1))
                begin
                    fper_next  = num_new;
                    state_next = BK_FIN;
                end
            end

            // load the result register once it is free
            BK_FIN:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next          = 1'b1;
                    res_next.min_code       = min_reg;
                    res_next.max_code       = max_reg;
                    res_next.base_code      = base_reg;
                    res_next.top_code       = top_reg;
                    res_next.mid_code       = mid_reg;
                    res_next.rising_count   = rcnt_reg;
                    res_next.falling_count  = fcnt_reg;
                    res_next.rise_spacing   = rper_reg;
                    res_next.fall_spacing   = fper_reg;
                    res_next.first_rising   = rfirst_reg;
                    res_next.first_falling  = ffirst_reg;
                    state_next              = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            t_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            t_reg         <= t_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        pmid_reg    <= pmid_next;
        bin_reg     <= bin_next;
        low_reg     <= low_next;
        lo_best_reg <= lo_best_next;
        lo_bin_reg  <= lo_bin_next;
        hi_best_reg <= hi_best_next;
        hi_bin_reg  <= hi_bin_next;
        base_reg    <= base_next;
        top_reg     <= top_next;
        mid_reg     <= mid_next;
        prev_reg    <= prev_next;
        skip_reg    <= skip_next;
        rcnt_reg    <= rcnt_next;
        fcnt_reg    <= fcnt_next;
        rfirst_reg  <= rfirst_next;
        rlast_reg   <= rlast_next;
        ffirst_reg  <= ffirst_next;
        flast_reg   <= flast_next;
        rper_reg    <= rper_next;
        fper_reg    <= fper_next;
        dnum_reg    <= dnum_next;
        drem_reg    <= drem_next;
        dden_reg    <= dden_next;
        dcnt_reg    <= dcnt_next;
        res_reg     <= res_next;
    end

endmodule

// ===== hw/rtl/waveform_pulse_measurement.sv =====
// Top level of the waveform pulse measurement block: APB register, front end,
// descriptor queue and back end. Depends on wpm_pkg, both interfaces and submodules.
//
//   port   kind        direction  moves
//   smp    valid/ready in         one sample request (sample, last)
//   res    valid/ready out        one summary per record
//   APB    psel/penable in        debounce_samples register, byte address 0
//
// Samples of a record are taken one per cycle into the sample store.
// After the closing sample the input stalls while the back end runs the histogram
// pass, the bin clearing, the crossing search and the two 20-step period divisions.
// After reset a sweep zeroes the histograms; no sample is taken then.
// A finished summary waits in the result register without holding the next record.
module waveform_pulse_measurement
(
    input  logic                                clk,
    input  logic                                rst_n,
    wpm_smp_if.sink                             smp,
    wpm_res_if.source                           res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wpm_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [wpm_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [wpm_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import wpm_pkg::*;

    logic [DEB_W-1:0] debounce_reg, debounce_next;
    logic             reg_sel;
    store_wr_t        st_wr;
    rec_t             rec_in, rec_out;
    logic             push, pop;
    q_stat_t          qstat;
    back_stat_t       bstat;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_DEBOUNCE);
    assign prdata  = reg_sel ? CFG_DATA_W'(debounce_reg) : '0;

    always_comb
    begin
        debounce_next = debounce_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            debounce_next = pwdata[DEB_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= '0;
        else
            debounce_reg <= debounce_next;
    end

    wpm_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp),
        .bstat (bstat),
        .qstat (qstat),
        .st_wr (st_wr),
        .push  (push),
        .rec   (rec_in)
    );

    wpm_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (rec_in),
        .pop   (pop),
        .dout  (rec_out),
        .qstat (qstat)
    );

    wpm_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .st_wr    (st_wr),
        .qstat    (qstat),
        .rec      (rec_out),
        .pop      (pop),
        .debounce (debounce_reg),
        .bstat    (bstat),
        .res      (res)
    );

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("descriptor queue overflow");

    a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !smp.ready)
        else $error("input taken while a record is pending");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.min_code <= res.max_code))
        else $error("result min above max");

    a_mid_order: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.base_code <= res.mid_code) && (res.mid_code <= res.top_code))
        else $error("midpoint outside base and top");

endmodule

// ===== tb/waveform_pulse_measurement_tb.sv =====
// Self-checking testbench for waveform_pulse_measurement: random records in,
// per-record summaries checked against an in-bench model. Needs wpm_pkg and both interfaces.
`timescale 1ns / 100ps

module waveform_pulse_measurement_tb;
    import wpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int SETTLE_CYCLES  = 120;
    localparam logic [CFG_ADDR_W-1:0] DEBOUNCE_ADDR = CFG_ADDR_W'(4 * REG_DEBOUNCE);
    localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR   = CFG_ADDR_W'(4);

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    last;
        int                      gap;
        bit                      hold;   // wait for all summaries before sending
    } sample_req_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    wpm_smp_if smp_ch();
    wpm_res_if res_ch();

    waveform_pulse_measurement dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .smp     (smp_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sample_req_t pending_samples[$];
    res_t        expected_summaries[$];
    int          record_samples[$];
    int          debounce_cfg;
    int          fail_count;
    int          gap_cnt;
    int          res_stall;
    int          idle_cycles;
    bit          smp_fired;
    bit          res_fired;
    int          items_queued;

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // summary of one record, mirrors the block's measurement
    function automatic res_t measure_record(input int s[$], input int deb);
        res_t r;
        int   lo_hist[NBINS];
        int   hi_hist[NBINS];
        int   n, mn, mx, pmid, base, top, mid, best, bin;
        int   r_cnt, r_first, r_last, f_cnt, f_first, f_last;
        longint per;
        n = s.size();
        mn = 32767;
        mx = -32768;
        foreach (s[i])
        begin
            if (s[i] < mn) mn = s[i];
            if (s[i] > mx) mx = s[i];
        end
        pmid = mn + (mx - mn) / 2;
        foreach (lo_hist[i])
        begin
            lo_hist[i] = 0;
            hi_hist[i] = 0;
        end
        for (int t = 0; t < n; t++)
        begin
            bin = (s[t] + 32768) >>> BIN_SHIFT;
            if (s[t] < pmid) lo_hist[bin]++;
            else hi_hist[bin]++;
        end
        // mode of each histogram, lowest bin wins ties
        base = -32768;
        best = 0;
        for (int i = 0; i < NBINS; i++)
            if (lo_hist[i] > best)
            begin
                best = lo_hist[i];
                base = (i << BIN_SHIFT) - 32768;
            end
        top = 32767;
        best = 0;
        for (int i = 0; i < NBINS; i++)
            if (hi_hist[i] > best)
            begin
                best = hi_hist[i];
                top = (i << BIN_SHIFT) - 32768;
            end
        mid = base + (top - base) / 2;
        // crossing search with hold-off after each edge
        r_cnt = 0; r_first = 0; r_last = 0;
        f_cnt = 0; f_first = 0; f_last = 0;
        for (int t = 1; t < n; t++)
        begin
            if (s[t] >= mid && s[t-1] < mid)
            begin
                if (r_cnt == 0) r_first = t;
                r_last = t;
                r_cnt++;
                t += deb;
            end
            else if (s[t] <= mid && s[t-1] > mid)
            begin
                if (f_cnt == 0) f_first = t;
                f_last = t;
                f_cnt++;
                t += deb;
            end
        end
        r.min_code      = SMP_W'(mn);
        r.max_code      = SMP_W'(mx);
        r.base_code     = SMP_W'(base);
        r.top_code      = SMP_W'(top);
        r.mid_code      = SMP_W'(mid);
        r.rising_count  = CNT_W'(r_cnt);
        r.falling_count = CNT_W'(f_cnt);
        per = (r_cnt < 2) ? 0 : ((longint'(r_last - r_first) << FRAC_W) / (r_cnt - 1));
        r.rise_spacing = PER_W'(per);
        per = (f_cnt < 2) ? 0 : ((longint'(f_last - f_first) << FRAC_W) / (f_cnt - 1));
        r.fall_spacing = PER_W'(per);
        r.first_rising  = IDX_W'(r_first);
        r.first_falling = IDX_W'(f_first);
        return r;
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // sample side: request acceptance and prediction
    always @(posedge clk)
    begin
        smp_fired = rst_n && smp_ch.valid && smp_ch.ready;
        if (smp_fired)
        begin
            if (record_samples.size() < RECORD_DEPTH)
                record_samples.push_back(int'(smp_ch.sample));
            if (smp_ch.last)
            begin
                expected_summaries.push_back(measure_record(record_samples, debounce_cfg));
                record_samples.delete();
            end
        end
    end

    // result side: compare with oldest expectation
    always @(posedge clk)
    begin
        res_t e;
        res_fired = rst_n && res_ch.valid && res_ch.ready;
        if (res_fired)
        begin
            res_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (expected_summaries.size() == 0)
            begin
                $error("summary received with none expected");
                fail_count++;
            end
            else
            begin
                e = expected_summaries.pop_front();
                check_field("min_code", e.min_code, res_ch.min_code);
                check_field("max_code", e.max_code, res_ch.max_code);
                check_field("base_code", e.base_code, res_ch.base_code);
                check_field("top_code", e.top_code, res_ch.top_code);
                check_field("mid_code", e.mid_code, res_ch.mid_code);
                check_field("rising_count", e.rising_count, res_ch.rising_count);
                check_field("falling_count", e.falling_count, res_ch.falling_count);
                check_field("rise_spacing", e.rise_spacing, res_ch.rise_spacing);
                check_field("fall_spacing", e.fall_spacing, res_ch.fall_spacing);
                check_field("first_rising", e.first_rising, res_ch.first_rising);
                check_field("first_falling", e.first_falling, res_ch.first_falling);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (smp_fired || res_fired)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        logic next_valid;
        sample_req_t req;
        if (rst_n && !(smp_ch.valid && !smp_fired))
        begin
            next_valid = 1'b0;
            if (pending_samples.size() > 0)
            begin
                if (pending_samples[0].hold && expected_summaries.size() > 0)
                    next_valid = 1'b0;
                else if (gap_cnt < pending_samples[0].gap)
                    gap_cnt++;
                else
                begin
                    req = pending_samples.pop_front();
                    smp_ch.sample <= req.sample;
                    smp_ch.last   <= req.last;
                    next_valid = 1'b1;
                    gap_cnt = 0;
                end
            end
            smp_ch.valid <= next_valid;
        end
    end

    // result ready with random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                res_stall--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic push_sample(input int v, input bit is_last, input bit busy_mode,
                               input bit hold);
        sample_req_t req;
        req.sample = SMP_W'(v);
        req.last   = is_last;
        req.gap    = busy_mode ? 0 : $urandom_range(0, 5);
        req.hold   = hold;
        pending_samples.push_back(req);
        items_queued++;
    endtask

    // one record of square-ish, random or flat content
    task automatic push_record(input int n);
        int  kind, lo, hi, per, noise, v, phase;
        bit  busy_mode, hold;
        kind = $urandom_range(0, 9);
        busy_mode = ($urandom_range(0, 3) == 0);
        hold = ($urandom_range(0, 7) == 0);
        lo = $urandom_range(0, 65535) - 32768;
        hi = $urandom_range(0, 65535) - 32768;
        per = $urandom_range(2, 24);
        noise = $urandom_range(0, 40);
        phase = $urandom_range(0, per - 1);
        for (int i = 0; i < n; i++)
        begin
            if (kind < 7)
                v = (((i + phase) % per) < per / 2 ? lo : hi)
                    + $urandom_range(0, noise) - noise / 2;
            else if (kind < 9)
                v = $urandom_range(0, 65535) - 32768;
            else
                v = lo;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            push_sample(v, i == n - 1, busy_mode, hold && i == 0);
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || smp_ch.valid || expected_summaries.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DEBOUNCE_ADDR)
            debounce_cfg = value & 12'hfff;
    endtask

    task automatic random_phase(input int items);
        int start;
        start = items_queued;
        while (items_queued - start < items)
            push_record(($urandom_range(0, 19) == 0) ? $urandom_range(60, 300)
                                                      : $urandom_range(1, 40));
    endtask

    initial
    begin
        int settings[6];
        fail_count = 0;
        gap_cnt = 0;
        res_stall = 0;
        idle_cycles = 0;
        items_queued = 0;
        debounce_cfg = 0;
        smp_fired = 0;
        res_fired = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        smp_ch.last = 1'b0;
        res_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_write(DEBOUNCE_ADDR, 0);
        // directed: single-sample records at both extremes
        push_sample(32767, 1, 1, 0);
        push_sample(-32768, 1, 0, 0);
        // full-scale toggling
        push_sample(-32768, 0, 1, 0);
        push_sample(32767, 0, 1, 0);
        push_sample(-32768, 0, 1, 0);
        push_sample(32767, 0, 1, 0);
        push_sample(0, 1, 1, 0);
        // flat record: empty low histogram
        push_sample(5, 0, 0, 1);
        push_sample(5, 0, 0, 0);
        push_sample(5, 1, 0, 0);
        // two occupied bins in each histogram
        push_sample(0, 0, 0, 0);
        push_sample(8, 0, 0, 0);
        push_sample(100, 0, 0, 0);
        push_sample(108, 0, 0, 0);
        push_sample(0, 0, 0, 0);
        push_sample(100, 1, 0, 0);
        random_phase(250);
        wait_idle();

        // writes to an unmapped address change nothing
        cfg_write(UNUSED_ADDR, 3);
        random_phase(150);
        wait_idle();

        settings = '{1, 4095, 2, 0, 6, 4095};
        foreach (settings[k])
        begin
            cfg_write(DEBOUNCE_ADDR, settings[k]);
            random_phase(230);
            wait_idle();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
